// File: design/frm_pkg.sv
// shared types and constants of the frame rms level meter
package frm_pkg;

  localparam int MAX_FRAME_SAMPLES = 4096;
  localparam int MAX_CHANNELS      = 8;
  localparam int SAMPLE_CAP        = MAX_FRAME_SAMPLES * MAX_CHANNELS;
  localparam int CNT_W             = $clog2(SAMPLE_CAP + 1);
  localparam int SUM_W             = CNT_W + 30;
  localparam int CH_W              = 4;
  localparam int LEN_W             = 13;
  localparam int LVL_W             = 15;
  localparam int SILENT_LEVEL      = -12000;
  localparam int FLOOR_LEVEL       = -12700;
  localparam int LOG10_2_Q16       = 19728302;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [0:0] REG_CAPTURE_ENABLE = 1'b0;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [CH_W-1:0]  chans;
    logic             send;
  } job_t;

endpackage

// File: design/frm_ifs.sv
// stream interfaces for samples and frame results
interface frm_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample;
  logic              last_in_frame;
  logic [3:0]        channel_count;
  logic              send_flag;
  modport source(output valid, sample, last_in_frame, channel_count, send_flag, input ready);
  modport sink(input valid, sample, last_in_frame, channel_count, send_flag, output ready);
endinterface

interface frm_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] level_centibel;
  logic [31:0]        frame_number;
  logic [31:0]        frame_offset;
  logic [12:0]        frame_length;
  logic               frame_sent;
  modport source(output valid, level_centibel, frame_number, frame_offset, frame_length,
                 frame_sent, input ready);
  modport sink(input valid, level_centibel, frame_number, frame_offset, frame_length,
               frame_sent, output ready);
endinterface

// File: design/frame_rms_dbfs_meter_top.sv
// top level of the frame rms level meter with its register port
// Usage: signed 16-bit interleaved PCM samples enter on the samples channel, one per
// transaction, with last_in_frame set on the final sample, the frame's channel count and
// send flag. Each accepted frame gives one transaction on the results channel: level in
// 0.01 dBFS, frame index, offset in sample frames, length per channel and send flag.
// Register 0 (capture_enable) at byte address 0; writing 1 while it is 0 starts a new
// capture and clears lock, counters and the open frame. While 0, samples are taken and
// dropped.
// Samples are taken one per cycle; the accumulator stalls only when the four-entry job
// queue is full. The level unit handles one frame at a time, through its serial normalize
// shifter, the 32x32 squaring loop (16 steps each for the sum and the count) and the
// 17-step serial length divider; a silent frame skips the normalize shifter and the
// squaring loop.
// A result holds on the output register while the receiver stalls; the level unit then
// waits, and the queue and accumulator keep taking samples until the queue fills.
// Reset (rst, synchronous) clears capture_enable, all state and the queue.
module frame_rms_dbfs_meter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  frm_in_if.sink      samples,
  frm_out_if.source   results
);
  import frm_pkg::*;

  logic capture_enable;
  logic wr;
  logic clear;
  logic push;
  logic pop;
  logic full;
  logic not_empty;
  job_t push_job;
  job_t head;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && (paddr[2] == REG_CAPTURE_ENABLE);
  assign clear = wr && pwdata[0] && !capture_enable;
  assign prdata = (paddr[2] == REG_CAPTURE_ENABLE) ? {31'b0, capture_enable} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
    end else if (wr) begin
      capture_enable <= pwdata[0];
    end
  end

  frm_front u_front (
    .clk(clk), .rst(rst), .enable(capture_enable), .clear(clear), .queue_full(full),
    .push(push), .job(push_job), .samples(samples)
  );

  frm_queue u_queue (
    .clk(clk), .rst(rst || clear), .push(push), .push_job(push_job), .pop(pop),
    .full(full), .not_empty(not_empty), .head(head)
  );

  frm_back u_back (
    .clk(clk), .rst(rst), .clear(clear), .job_valid(not_empty), .job_in(head), .pop(pop),
    .results(results)
  );

endmodule

// File: design/frm_front.sv
// sample accumulator: sums squares per frame, checks the channel lock, emits frame jobs
module frm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          enable,
  input  logic          clear,
  input  logic          queue_full,
  output logic          push,
  output frm_pkg::job_t job,
  frm_in_if.sink        samples
);
  import frm_pkg::*;

  logic [SUM_W-1:0] square_sum;
  logic [CNT_W-1:0] samples_seen;
  logic [CH_W-1:0]  locked_channels;

  logic [15:0]      mag;
  logic [31:0]      sq;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] seen_add;
  logic             take;
  logic             ch_ok;

  assign samples.ready = !enable || !queue_full;
  assign take = samples.valid && samples.ready && enable;

  always_comb begin
    mag = samples.sample[15] ? 16'(-samples.sample) : 16'(samples.sample);
    sq = 32'(mag) * 32'(mag);
    if (samples_seen < CNT_W'(SAMPLE_CAP)) begin
      sum_add = square_sum + SUM_W'(sq);
      seen_add = samples_seen + 1'b1;
    end else begin
      sum_add = square_sum;
      seen_add = samples_seen;
    end
    ch_ok = (samples.channel_count != '0) &&
            (samples.channel_count <= CH_W'(MAX_CHANNELS));
    job.sum = sum_add;
    job.count = seen_add;
    job.chans = samples.channel_count;
    job.send = samples.send_flag;
    push = take && samples.last_in_frame && ch_ok &&
           (locked_channels == '0 || locked_channels == samples.channel_count);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      square_sum <= '0;
      samples_seen <= '0;
      locked_channels <= '0;
    end else if (take) begin
      if (samples.last_in_frame) begin
        square_sum <= '0;
        samples_seen <= '0;
        if (ch_ok && locked_channels == '0) begin
          locked_channels <= samples.channel_count;
        end
      end else begin
        square_sum <= sum_add;
        samples_seen <= seen_add;
      end
    end
  end

endmodule

// File: design/frm_queue.sv
// short job queue between the accumulator and the level unit
module frm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frm_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output frm_pkg::job_t head
);
  import frm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t               mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("job queue underflow");

endmodule

// File: design/frm_back.sv
// level unit: log2 by normalize and repeated squaring, length division, counters
module frm_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          job_valid,
  input  frm_pkg::job_t job_in,
  output logic          pop,
  frm_out_if.source     results
);
  import frm_pkg::*;

  localparam int LOG_W = 22;
  localparam int E_W   = 6;
  localparam int NUM_W = CNT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_SQR, ST_FIX, ST_DIV, ST_MUL, ST_RES, ST_OUT
  } state_t;

  state_t           state;
  job_t             job;
  logic             silent;
  logic             which;
  logic [SUM_W-1:0] x;
  logic [E_W-1:0]   e;
  logic [31:0]      m;
  logic [63:0]      prod;
  logic [3:0]       it;
  logic [15:0]      frac;
  logic [LOG_W-1:0] log_s;
  logic [LOG_W-1:0] log_n;
  logic [NUM_W-1:0] num;
  logic [CH_W-1:0]  rem;
  logic [4:0]       dcnt;
  logic signed [49:0] p;
  logic [31:0]      frame_counter;
  logic [31:0]      offset_counter;

  logic [32:0]        t;
  logic [15:0]        frac_next;
  logic [CH_W:0]      r2;
  logic signed [23:0] d;
  logic signed [50:0] pb;
  logic signed [18:0] lvl;
  logic signed [LVL_W-1:0] lvl_c;
  logic [LEN_W-1:0]   len;

  localparam logic signed [49:0] COEF = 50'(LOG10_2_Q16);

  always_comb begin
    t = prod[63:31];
    frac_next = {frac[14:0], t[32]};
    r2 = {rem, num[NUM_W-1]};
    d = 24'(log_s) - 24'(log_n) - 24'(30 * 65536);
    pb = 51'(p) + 51'(64'sd2147483648);
    lvl = pb[50:32];
    if (silent) lvl_c = LVL_W'(SILENT_LEVEL);
    else if (lvl < 19'(FLOOR_LEVEL)) lvl_c = LVL_W'(FLOOR_LEVEL);
    else if (lvl > 19'sd0) lvl_c = '0;
    else lvl_c = LVL_W'(lvl);
    len = (num > NUM_W'(MAX_FRAME_SAMPLES)) ? LEN_W'(MAX_FRAME_SAMPLES) : LEN_W'(num);
    pop = (state == ST_IDLE) && job_valid;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state <= ST_IDLE;
      results.valid <= 1'b0;
      frame_counter <= '0;
      offset_counter <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            job <= job_in;
            silent <= (job_in.sum == '0);
            which <= 1'b0;
            x <= job_in.sum;
            e <= E_W'(SUM_W - 1);
            num <= NUM_W'(job_in.count) + NUM_W'(job_in.chans) - 1'b1;
            rem <= '0;
            dcnt <= '0;
            state <= (job_in.sum == '0) ? ST_DIV : ST_NORM;
          end
        end
        ST_NORM: begin
          if (x[SUM_W-1]) begin
            m <= x[SUM_W-1 -: 32];
            it <= '0;
            frac <= '0;
            state <= ST_SQR;
          end else begin
            x <= {x[SUM_W-2:0], 1'b0};
            e <= e - 1'b1;
          end
        end
        ST_SQR: begin
          prod <= 64'(m) * 64'(m);
          state <= ST_FIX;
        end
        ST_FIX: begin
          frac <= frac_next;
          m <= t[32] ? t[32:1] : t[31:0];
          it <= it + 1'b1;
          if (it == 4'd15) begin
            if (!which) begin
              log_s <= {e, frac_next};
              which <= 1'b1;
              x <= SUM_W'(job.count);
              e <= E_W'(SUM_W - 1);
              state <= ST_NORM;
            end else begin
              log_n <= {e, frac_next};
              state <= ST_DIV;
            end
          end else begin
            state <= ST_SQR;
          end
        end
        ST_DIV: begin
          // restoring division, quotient bits shift into num
          if (r2 >= (CH_W + 1)'(job.chans)) begin
            rem <= CH_W'(r2 - (CH_W + 1)'(job.chans));
            num <= {num[NUM_W-2:0], 1'b1};
          end else begin
            rem <= r2[CH_W-1:0];
            num <= {num[NUM_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 5'(NUM_W - 1)) state <= ST_MUL;
        end
        ST_MUL: begin
          p <= 50'(d) * COEF;
          state <= ST_RES;
        end
        ST_RES: begin
          results.valid <= 1'b1;
          results.level_centibel <= lvl_c;
          results.frame_number <= frame_counter;
          results.frame_offset <= offset_counter;
          results.frame_length <= len;
          results.frame_sent <= job.send;
          frame_counter <= frame_counter + 1'b1;
          offset_counter <= offset_counter + 32'(len);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (results.ready) begin
            results.valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.level_centibel <= 15'sd0 &&
                       results.level_centibel >= LVL_W'(FLOOR_LEVEL)))
    else $error("level out of range");
  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> state == ST_OUT)
    else $error("result valid outside output state");

endmodule

// File: tb/frame_rms_dbfs_meter_top_tb.sv
// self-checking testbench of the frame rms level meter top level
`timescale 1ns / 100ps

module frame_rms_dbfs_meter_top_tb;
  import frm_pkg::*;

  typedef struct packed {
    logic signed [14:0] lvl;
    logic [31:0]        num;
    logic [31:0]        off;
    logic [12:0]        len;
    logic               sent;
  } frame_res_t;

  typedef struct {
    logic signed [15:0] smp;
    logic               last;
    logic [3:0]         ch;
    logic               snd;
    logic               has_lvl;
    logic signed [14:0] lvl;
  } drow_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  frm_in_if samples ();
  frm_out_if results ();

  frame_rms_dbfs_meter_top dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .samples(samples.sink), .results(results.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("** frame_rms_dbfs_meter_top: FAILED **");
    $finish;
  end

  // predictor state
  logic        cap_en;
  logic [63:0] sq_sum;
  logic [63:0] n_seen;
  logic [3:0]  lock_ch;
  logic [31:0] frame_cnt;
  logic [31:0] offset_cnt;

  frame_res_t frames_due[$];
  logic signed [14:0] lvl_due[$];
  logic               lvl_known[$];
  int errors = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_cycles = 0;
  int items_sent = 0;

  function automatic longint log2_q16(logic [63:0] x);
    int e;
    logic [63:0] m;
    longint frac;
    e = 63;
    frac = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e <= 31) m = x << (31 - e);
    else m = x >> (e - 31);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

  function automatic int dbfs_centi(logic [63:0] s, logic [63:0] n);
    longint d, p, lv;
    logic [63:0] b;
    if (s == 0) return SILENT_LEVEL;
    d = log2_q16(s) - log2_q16(n) - longint'(30) * 65536;
    p = d * longint'(LOG10_2_Q16);
    b = p + (longint'(1) << 31) + (longint'(1) << 52);
    lv = longint'(b >> 32) - (longint'(1) << 20);
    if (lv < FLOOR_LEVEL) lv = FLOOR_LEVEL;
    if (lv > 0) lv = 0;
    return int'(lv);
  endfunction

  task automatic meter_config(logic [31:0] v);
    if (v[0] && !cap_en) begin
      sq_sum = 0; n_seen = 0; lock_ch = 0; frame_cnt = 0; offset_cnt = 0;
    end
    cap_en = v[0];
  endtask

  // returns 1 when the sample closes an accepted frame
  function automatic bit meter_sample(logic signed [15:0] smp, logic last, logic [3:0] ch,
                                      logic snd, output frame_res_t r);
    logic [63:0] mag, s, n, len;
    r = '0;
    if (!cap_en) return 0;
    mag = smp < 0 ? 64'(-int'(smp)) : 64'(smp);
    if (n_seen < SAMPLE_CAP) begin
      sq_sum += mag * mag;
      n_seen++;
    end
    if (!last) return 0;
    s = sq_sum; n = n_seen;
    sq_sum = 0; n_seen = 0;
    if (ch == 0 || ch > MAX_CHANNELS) return 0;
    if (lock_ch == 0) lock_ch = ch;
    if (lock_ch != ch) return 0;
    len = (n + ch - 1) / ch;
    if (len > MAX_FRAME_SAMPLES) len = MAX_FRAME_SAMPLES;
    r.lvl = 15'(dbfs_centi(s, n));
    r.num = frame_cnt;
    r.off = offset_cnt;
    r.len = 13'(len);
    r.sent = snd;
    frame_cnt++;
    offset_cnt += 32'(len);
    return 1;
  endfunction

  task automatic apb_write(logic [2:0] a, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == {REG_CAPTURE_ENABLE, 2'b00}) meter_config(v);
  endtask

  task automatic drive_sample(logic signed [15:0] smp, logic last, logic [3:0] ch,
                              logic snd, bit known, logic signed [14:0] lvl);
    frame_res_t r;
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.sample <= smp;
    samples.last_in_frame <= last;
    samples.channel_count <= ch;
    samples.send_flag <= snd;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    items_sent++;
    if (meter_sample(smp, last, ch, snd, r)) begin
      frames_due = {frames_due, r};
      lvl_known = {lvl_known, known};
      lvl_due = {lvl_due, lvl};
    end
  endtask

  task automatic go_idle();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // random frame with mostly the locked channel count and small lengths
  task automatic random_frame(logic [3:0] ch);
    int len, kind;
    logic signed [15:0] v;
    logic [3:0] c;
    kind = $urandom_range(99);
    len = (kind < 3) ? $urandom_range(128, 64) : $urandom_range(40, 1);
    c = ch;
    if (kind >= 3 && kind < 10) c = 4'($urandom_range(15));
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(5))
        0: v = 16'sh8000;
        1: v = 16'sh7fff;
        2: v = 16'sd0;
        3: v = 16'($urandom_range(7)) - 16'sd3;
        default: v = 16'($urandom);
      endcase
      drive_sample(v, i == len - 1, c, 1'($urandom), 0, '0);
    end
  endtask

  drow_t dtab[] = '{
    '{16'sd0, 1'b1, 4'd1, 1'b0, 1'b1, -15'sd12000},
    '{16'sh8000, 1'b1, 4'd1, 1'b1, 1'b1, 15'sd0},
    '{16'sh7fff, 1'b0, 4'd1, 1'b0, 1'b0, '0},
    '{16'sh8000, 1'b1, 4'd1, 1'b1, 1'b0, '0},
    '{16'sd1, 1'b1, 4'd1, 1'b0, 1'b0, '0},
    '{16'sh7fff, 1'b1, 4'd2, 1'b1, 1'b0, '0},
    '{16'sd5, 1'b1, 4'd0, 1'b1, 1'b0, '0},
    '{16'sd5, 1'b1, 4'd9, 1'b1, 1'b0, '0},
    '{16'sd5, 1'b1, 4'd15, 1'b0, 1'b0, '0},
    '{-16'sd1, 1'b0, 4'd1, 1'b0, 1'b0, '0},
    '{16'sd3, 1'b0, 4'd1, 1'b0, 1'b0, '0},
    '{16'sd0, 1'b1, 4'd1, 1'b1, 1'b0, '0},
    '{16'sd0, 1'b0, 4'd1, 1'b0, 1'b0, '0},
    '{16'sd0, 1'b1, 4'd1, 1'b0, 1'b1, -15'sd12000}
  };

  // result checker
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected result lvl=%0d num=%0d", $time,
                 results.level_centibel, results.frame_number);
        errors++;
      end else begin
        frame_res_t e;
        logic k;
        logic signed [14:0] dl;
        e = frames_due.pop_front();
        k = lvl_known.pop_front();
        dl = lvl_due.pop_front();
        if (k && dl != e.lvl) begin
          $display("%0t: predicted level exp=%0d act=%0d", $time, dl, e.lvl);
          errors++;
        end
        if (results.level_centibel !== e.lvl) begin
          $display("%0t: level exp=%0d act=%0d", $time, e.lvl, results.level_centibel);
          errors++;
        end
        if (results.frame_number !== e.num) begin
          $display("%0t: frame_number exp=%0d act=%0d", $time, e.num, results.frame_number);
          errors++;
        end
        if (results.frame_offset !== e.off) begin
          $display("%0t: frame_offset exp=%0d act=%0d", $time, e.off, results.frame_offset);
          errors++;
        end
        if (results.frame_length !== e.len) begin
          $display("%0t: frame_length exp=%0d act=%0d", $time, e.len, results.frame_length);
          errors++;
        end
        if (results.frame_sent !== e.sent) begin
          $display("%0t: frame_sent exp=%0d act=%0d", $time, e.sent, results.frame_sent);
          errors++;
        end
      end
    end
  end

  // receiver stalls, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      results.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      results.ready <= !($urandom_range(99) < snk_idle_pct);
    end
  end

  initial begin
    int nitems;
    logic [3:0] ch;
    samples.valid = 1'b0;
    samples.sample = '0;
    samples.last_in_frame = 1'b0;
    samples.channel_count = '0;
    samples.send_flag = 1'b0;
    cap_en = 0;
    meter_config(0);
    sq_sum = 0; n_seen = 0; lock_ch = 0; frame_cnt = 0; offset_cnt = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled: samples are dropped
    drive_sample(16'sd100, 1'b1, 4'd1, 1'b0, 0, '0);
    go_idle();
    apb_write(3'd4, 32'd1);
    apb_write({REG_CAPTURE_ENABLE, 2'b00}, 32'd1);
    foreach (dtab[i])
      drive_sample(dtab[i].smp, dtab[i].last, dtab[i].ch, dtab[i].snd,
                   dtab[i].has_lvl, dtab[i].lvl);
    go_idle();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 75 : 0;
      snk_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 17 : 0;
      apb_write({REG_CAPTURE_ENABLE, 2'b00}, 32'd0);
      if (ph == 1) begin
        drive_sample(16'sd7, 1'b1, 4'd1, 1'b0, 0, '0);
        samples.valid <= 1'b0;
      end
      apb_write({REG_CAPTURE_ENABLE, 2'b00}, 32'd1);
      apb_write({REG_CAPTURE_ENABLE, 2'b00}, 32'd1);
      ch = 4'($urandom_range(MAX_CHANNELS, 1));
      if (ph == 2) hold_cycles = 3000;
      nitems = items_sent + 400;
      while (items_sent < nitems) random_frame(ch);
      go_idle();
    end
    // capture is switched off, then the remaining results drain before the verdict
    apb_write({REG_CAPTURE_ENABLE, 2'b00}, 32'd0);
    go_idle();

    if (errors == 0 && frames_due.size() == 0) begin
      $display("** frame_rms_dbfs_meter_top: PASSED **");
    end else begin
      $display("** frame_rms_dbfs_meter_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
design/frm_pkg.sv
design/frm_ifs.sv
design/frm_front.sv
design/frm_queue.sv
design/frm_back.sv
design/frame_rms_dbfs_meter_top.sv
tb/frame_rms_dbfs_meter_top_tb.sv
